// ----- sv/gacc_pkg.sv -----
package gacc_pkg;

  // Field and register widths.
  localparam int COORD_W = 32;
  localparam int ACCEL_W = 32;
  localparam int GM_W    = 32;
  localparam int SHIFT_W = 6;
  localparam int ADDR_W  = 3;
  localparam int NAX     = 3;

  // Derived datapath widths.
  localparam int SQ_W   = 2 * COORD_W;
  localparam int PROD_W = GM_W + COORD_W;
  localparam int NUM_W  = PROD_W + (1 << SHIFT_W) - 1;
  localparam int R_W    = COORD_W;
  localparam int REM_W  = R_W + 3;
  localparam int DEN_W  = 3 * R_W;
  localparam int DIV_W  = DEN_W + ACCEL_W;

  typedef enum logic {
    REG_GRAV  = 1'b0,
    REG_SHIFT = 1'b1
  } reg_idx_e;

  typedef logic [NAX-1:0][NUM_W-1:0] num_vec_t;

  // Per-item data that rides alongside the radius computation.
  typedef struct packed {
    num_vec_t       num;
    logic [NAX-1:0] neg;
    logic           zero;
  } side_t;

endpackage

// ----- sv/gacc_front.sv -----
module gacc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [gacc_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [gacc_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [gacc_pkg::COORD_W-1:0] pos_z_i,
  input  logic [gacc_pkg::GM_W-1:0]         gm_i,
  input  logic [gacc_pkg::SHIFT_W-1:0]      shift_i,
  output logic                              valid_o,
  output logic [gacc_pkg::SQ_W-1:0]         r2_o,
  output gacc_pkg::side_t                   side_o
);
  import gacc_pkg::*;

  logic [NAX-1:0][COORD_W-1:0] pos;
  logic [NAX-1:0][COORD_W-1:0] mag_d, mag_q;
  logic [NAX-1:0]              neg_d, neg1_q, neg2_q, neg3_q;
  logic                        zero_d, zero1_q, zero2_q, zero3_q;
  logic [NAX-1:0][SQ_W-1:0]    sq_d, sq_q;
  logic [NAX-1:0][PROD_W-1:0]  prod_d, prod_q;
  num_vec_t                    num_d, num_q;
  logic [SQ_W-1:0]             r2_d, r2_q;
  logic [2:0]                  v_q;

  assign pos = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      neg_d[a]  = pos[a][COORD_W-1];
      mag_d[a]  = neg_d[a] ? (~pos[a] + 1'b1) : pos[a];
      sq_d[a]   = SQ_W'(mag_q[a]) * SQ_W'(mag_q[a]);
      prod_d[a] = PROD_W'(gm_i) * PROD_W'(mag_q[a]);
      num_d[a]  = NUM_W'(prod_q[a]) << shift_i;
    end
    zero_d = (pos == '0);
    // The true sum of squares stays below 2^SQ_W.
    r2_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      neg1_q  <= neg_d;
      zero1_q <= zero_d;
      sq_q    <= sq_d;
      prod_q  <= prod_d;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      r2_q    <= r2_d;
      num_q   <= num_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  assign valid_o     = v_q[2];
  assign r2_o        = r2_q;
  assign side_o.num  = num_q;
  assign side_o.neg  = neg3_q;
  assign side_o.zero = zero3_q;

endmodule

// ----- sv/gacc_isqrt.sv -----
module gacc_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [gacc_pkg::SQ_W-1:0] r2_i,
  input  gacc_pkg::side_t           side_i,
  output logic                      valid_o,
  output logic [gacc_pkg::R_W-1:0]  root_o,
  output gacc_pkg::side_t           side_o
);
  import gacc_pkg::*;

  // One root bit per stage, two radicand bits consumed per stage.
  logic [R_W-1:0]             v_q;
  logic [R_W-1:0][SQ_W-1:0]   rad_q;
  logic [R_W-1:0][REM_W-1:0]  rem_q;
  logic [R_W-1:0][R_W-1:0]    root_q;
  side_t                      side_q [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stage
    logic             v_in;
    logic [SQ_W-1:0]  rad_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [R_W-1:0]   root_in;
    side_t            side_in;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = r2_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = {{(REM_W-R_W-2){1'b0}}, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_in << 2;
        rem_q[s]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {root_in[R_W-2:0], ge};
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

// ----- sv/gacc_cube.sv -----
module gacc_cube (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [gacc_pkg::R_W-1:0]   root_i,
  input  gacc_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic [gacc_pkg::DEN_W-1:0] den_o,
  output gacc_pkg::side_t            side_o
);
  import gacc_pkg::*;

  logic [2:0]         v_q;
  logic [R_W-1:0]     r1_q;
  logic [2*R_W-1:0]   rr_q, lo_q, hi_q;
  logic [DEN_W-1:0]   den_q;
  side_t              s1_q, s2_q, s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // r*r, then the 2*R_W by R_W product split into two R_W by R_W halves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q  <= (2*R_W)'(root_i) * (2*R_W)'(root_i);
      r1_q  <= root_i;
      s1_q  <= side_i;
      lo_q  <= (2*R_W)'(rr_q[R_W-1:0]) * (2*R_W)'(r1_q);
      hi_q  <= (2*R_W)'(rr_q[2*R_W-1:R_W]) * (2*R_W)'(r1_q);
      s2_q  <= s1_q;
      den_q <= {hi_q, {R_W{1'b0}}} + DEN_W'(lo_q);
      s3_q  <= s2_q;
    end
  end

  assign valid_o = v_q[2];
  assign den_o   = den_q;
  assign side_o  = s3_q;

endmodule

// ----- sv/gacc_div.sv -----
module gacc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [gacc_pkg::DEN_W-1:0]   den_i,
  input  gacc_pkg::side_t              side_i,
  output logic                         valid_o,
  output logic signed [gacc_pkg::ACCEL_W-1:0] acc_x_o,
  output logic signed [gacc_pkg::ACCEL_W-1:0] acc_y_o,
  output logic signed [gacc_pkg::ACCEL_W-1:0] acc_z_o,
  output logic                         zero_radius_o,
  output logic                         clipped_o
);
  import gacc_pkg::*;

  // Head stage: a quotient of 2^ACCEL_W or more always saturates.
  logic                       vh_q;
  logic [NAX-1:0][DIV_W-1:0]  remh_q;
  logic [DEN_W-1:0]           denh_q;
  logic [NAX-1:0]             ovfh_q, negh_q;
  logic                       zeroh_q;
  logic [NAX-1:0]             ovf_d;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      ovf_d[a] = (DIV_W'(side_i.num[a]) >= {den_i, {ACCEL_W{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else if (en_i) begin
      vh_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NAX; a++) begin
        remh_q[a] <= DIV_W'(side_i.num[a]);
      end
      denh_q  <= den_i;
      ovfh_q  <= ovf_d;
      negh_q  <= side_i.neg;
      zeroh_q <= side_i.zero;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  logic [ACCEL_W-1:0]                     v_q;
  logic [ACCEL_W-1:0][NAX-1:0][DIV_W-1:0] rem_q;
  logic [ACCEL_W-1:0][NAX-1:0][ACCEL_W-1:0] quo_q;
  logic [ACCEL_W-1:0][DEN_W-1:0]          den_q;
  logic [ACCEL_W-1:0][NAX-1:0]            ovf_q, neg_q;
  logic [ACCEL_W-1:0]                     zero_q;

  for (genvar s = 0; s < ACCEL_W; s++) begin : g_stage
    localparam int Bit = ACCEL_W - 1 - s;
    logic                       v_in, zero_in;
    logic [NAX-1:0][DIV_W-1:0]  rem_in, rem_d;
    logic [NAX-1:0][ACCEL_W-1:0] quo_in, quo_d;
    logic [DEN_W-1:0]           den_in;
    logic [NAX-1:0]             ovf_in, neg_in;
    logic [DIV_W-1:0]           dsh;

    if (s == 0) begin : g_first
      assign v_in    = vh_q;
      assign rem_in  = remh_q;
      assign quo_in  = '0;
      assign den_in  = denh_q;
      assign ovf_in  = ovfh_q;
      assign neg_in  = negh_q;
      assign zero_in = zeroh_q;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    assign dsh = DIV_W'(den_in) << Bit;

    always_comb begin
      for (int a = 0; a < NAX; a++) begin
        rem_d[a] = rem_in[a];
        quo_d[a] = quo_in[a];
        if (!ovf_in[a] && (rem_in[a] >= dsh)) begin
          rem_d[a]      = rem_in[a] - dsh;
          quo_d[a][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        ovf_q[s]  <= ovf_in;
        neg_q[s]  <= neg_in;
        zero_q[s] <= zero_in;
      end
    end
  end

  // Output stage: saturate, apply the sign opposite to the position.
  localparam logic [ACCEL_W:0] LimPos = (ACCEL_W+1)'(1) << (ACCEL_W - 1);
  localparam logic [ACCEL_W:0] LimNeg = LimPos - 1'b1;

  logic                          vo_q, zero_o_q, clip_o_q;
  logic [NAX-1:0][ACCEL_W-1:0]   acc_d, acc_q;
  logic                          clip_d;

  always_comb begin
    logic [ACCEL_W:0] lim, mag;
    logic             clip_a;
    clip_d = 1'b0;
    for (int a = 0; a < NAX; a++) begin
      lim    = neg_q[ACCEL_W-1][a] ? LimNeg : LimPos;
      clip_a = ovf_q[ACCEL_W-1][a] || ({1'b0, quo_q[ACCEL_W-1][a]} > lim);
      mag    = clip_a ? lim : {1'b0, quo_q[ACCEL_W-1][a]};
      if (!neg_q[ACCEL_W-1][a]) begin
        mag = ~mag + 1'b1;
      end
      acc_d[a] = zero_q[ACCEL_W-1] ? '0 : mag[ACCEL_W-1:0];
      clip_d   = clip_d | clip_a;
    end
    if (zero_q[ACCEL_W-1]) begin
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[ACCEL_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q    <= acc_d;
      clip_o_q <= clip_d;
      zero_o_q <= zero_q[ACCEL_W-1];
    end
  end

  assign valid_o       = vo_q;
  assign acc_x_o       = acc_q[0];
  assign acc_y_o       = acc_q[1];
  assign acc_z_o       = acc_q[2];
  assign zero_radius_o = zero_o_q;
  assign clipped_o     = clip_o_q;

endmodule

// ----- sv/gravity_acceleration.sv -----
// Point-mass gravitational acceleration, a = -GM * p * 2^accel_shift / r^3.
//
// Input stream (s_axis_*): one request per position, tdata carries pos_x,
// pos_y and pos_z as signed 32-bit values. Output stream (m_axis_*): one
// request per position with acc_x, acc_y, acc_z, zero_radius and clipped.
// Both channels transfer when tvalid and tready are high at a clock edge.
//
// The APB port holds grav_param at address 0 and accel_shift at address 4.
// Registers should only be written while no request is in flight.
//
// The pipeline has 3 front-end stages (magnitude, squares and GM*|p|,
// sum and shift), 32 square-root stages, 3 stages for r^3, one saturation
// check, 32 divider stages and the output register. The square root and the
// divider each retire one result bit per stage, which sets that depth.
// The pipeline takes one request per cycle unless a finished result is held.
//
// Reset clears the configuration registers and all valid bits. When the receiver
// stalls a finished result the whole pipeline holds, and s_axis_tready falls until
// the output register is taken; nothing is dropped or repeated.
module gravity_acceleration (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  input  logic [3*gacc_pkg::COORD_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] acc_x, [63:32] acc_y, [95:64] acc_z, [96] zero_radius,
  // [97] clipped, [103:98] zero
  output logic [((3*gacc_pkg::ACCEL_W+2+7)/8)*8-1:0] m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gacc_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gacc_pkg::*;

  localparam int OutW = ((3*ACCEL_W+2+7)/8)*8;

  logic [GM_W-1:0]    gm_q;
  logic [SHIFT_W-1:0] shift_q;
  reg_idx_e           reg_idx;
  logic               en;

  // Configuration registers; the register index is the word address.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gm_q    <= '0;
      shift_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_GRAV:  gm_q    <= pwdata[GM_W-1:0];
        REG_SHIFT: shift_q <= pwdata[SHIFT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRAV:  prdata = 32'(gm_q);
      REG_SHIFT: prdata = 32'(shift_q);
      default:   prdata = '0;
    endcase
  end

  // Every stage advances together unless a finished result is held.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic            f_valid, q_valid, c_valid;
  logic [SQ_W-1:0] r2;
  logic [R_W-1:0]  root;
  logic [DEN_W-1:0] den;
  side_t           f_side, q_side, c_side;
  logic signed [ACCEL_W-1:0] acc_x, acc_y, acc_z;
  logic            zero_radius, clipped;

  gacc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pos_x_i (s_axis_tdata[COORD_W-1:0]),
    .pos_y_i (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .pos_z_i (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .gm_i    (gm_q),
    .shift_i (shift_q),
    .valid_o (f_valid),
    .r2_o    (r2),
    .side_o  (f_side)
  );

  gacc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .r2_i    (r2),
    .side_i  (f_side),
    .valid_o (q_valid),
    .root_o  (root),
    .side_o  (q_side)
  );

  gacc_cube u_cube (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_valid),
    .root_i  (root),
    .side_i  (q_side),
    .valid_o (c_valid),
    .den_o   (den),
    .side_o  (c_side)
  );

  gacc_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (c_valid),
    .den_i         (den),
    .side_i        (c_side),
    .valid_o       (m_axis_tvalid),
    .acc_x_o       (acc_x),
    .acc_y_o       (acc_y),
    .acc_z_o       (acc_z),
    .zero_radius_o (zero_radius),
    .clipped_o     (clipped)
  );

  assign m_axis_tdata = OutW'({clipped, zero_radius, acc_z, acc_y, acc_x});

endmodule

// ----- sim/testbench.sv -----
// Streams positions through the gravity block and checks every acceleration
// request against a predictor that works in wide integer arithmetic.
module testbench;
  import gacc_pkg::*;

  localparam int OUT_W  = ((3*ACCEL_W+2+7)/8)*8;
  localparam int DRAIN  = 90;  // longer than the pipeline takes to empty
  localparam int HOLD_N = 400; // long receiver hold-off, in cycles

  typedef struct packed {
    logic [ACCEL_W-1:0] acc_z;
    logic [ACCEL_W-1:0] acc_y;
    logic [ACCEL_W-1:0] acc_x;
    logic               zero_radius;
    logic               clipped;
  } accel_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [3*COORD_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  gravity_acceleration i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Our own copy of the configuration registers.
  logic [GM_W-1:0]    gm_reg;
  logic [SHIFT_W-1:0] shift_reg;

  accel_t accel_q[$];     // expected accelerations, oldest first
  int     n_errors   = 0;
  int     n_sent     = 0;
  int     n_checked  = 0;
  int     n_clipped  = 0;
  int     n_origin   = 0;
  int     burst_left = 0;
  int     rx_mode    = 0; // 0: always ready, 1: random stalls, 2: mostly stalled
  bit     hold_req   = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Integer square root rounded down, then the exact truncated quotient
  // GM*|p|*2^shift / r^3 per axis, saturated and given the opposite sign.
  function automatic accel_t predict_accel(logic [3*COORD_W-1:0] pos);
    logic [255:0] mag[3];
    logic         neg[3];
    logic [255:0] r2, r, cand, den, num, lim, q;
    logic [ACCEL_W-1:0] res[3];
    accel_t a;
    r2 = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = pos[i*COORD_W + COORD_W-1];
      mag[i] = '0;
      mag[i][COORD_W-1:0] = neg[i] ? -pos[i*COORD_W +: COORD_W] : pos[i*COORD_W +: COORD_W];
      r2 = r2 + mag[i] * mag[i];
    end
    a = '0;
    if (r2 == 0) begin
      a.zero_radius = 1'b1;
      return a;
    end
    r = '0;
    for (int b = 50; b >= 0; b--) begin
      cand = r | (256'd1 << b);
      if (cand * cand <= r2) r = cand;
    end
    den = r * r * r;
    for (int i = 0; i < 3; i++) begin
      num = (256'(gm_reg) * mag[i]) << shift_reg;
      // A negative coordinate gives a positive result, so the bound is one less.
      lim = neg[i] ? (256'd1 << (ACCEL_W-1)) - 1 : (256'd1 << (ACCEL_W-1));
      if (num >= den * (lim + 1)) begin
        a.clipped = 1'b1;
        q = lim;
      end else begin
        q = num / den;
      end
      res[i] = neg[i] ? q[ACCEL_W-1:0] : -q[ACCEL_W-1:0];
    end
    a.acc_x = res[0];
    a.acc_y = res[1];
    a.acc_z = res[2];
    return a;
  endfunction

  // One APB write: setup cycle, then access cycle.
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_GRAV) gm_reg = value;
    else shift_reg = value[SHIFT_W-1:0];
  endtask

  // Lets the pipeline empty completely so the registers may be changed.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (accel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] gm, logic [31:0] shift);
    wait_idle();
    apb_write(REG_GRAV, gm);
    apb_write(REG_SHIFT, shift);
  endtask

  // Sends one position request. The sender runs in bursts; between bursts
  // tvalid may drop for a random gap. The expectation is queued on acceptance.
  task automatic send_pos(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [COORD_W-1:0] z);
    int  gap;
    bit  rdy;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    accel_q.push_back(predict_accel({z, y, x}));
    n_sent++;
  endtask

  // Random coordinate with a random magnitude range, so that both small and
  // huge positions occur and every bit gets exercised.
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    int w;
    v = $urandom();
    w = $urandom_range(0, 3);
    case (w)
      0: v = 32'($signed(v[7:0]));
      1: v = 32'($signed(v[17:0]));
      default: ;
    endcase
    if ($urandom_range(0, 40) == 0) v = '0;
    return v;
  endfunction

  // Receiver: ready pattern depends on rx_mode; a hold request blocks it until
  // the counter kept here reaches HOLD_N.
  initial begin
    int held;
    held = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held == HOLD_N) begin
          hold_req = 0;
          held = 0;
        end
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Checker: a transfer at the next edge is known at the negedge before it.
  initial begin
    accel_t got, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3*ACCEL_W+1:0] == '0 ? '0 : '0;
        got.acc_x       = m_axis_tdata[0 +: ACCEL_W];
        got.acc_y       = m_axis_tdata[ACCEL_W +: ACCEL_W];
        got.acc_z       = m_axis_tdata[2*ACCEL_W +: ACCEL_W];
        got.zero_radius = m_axis_tdata[3*ACCEL_W];
        got.clipped     = m_axis_tdata[3*ACCEL_W+1];
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = accel_q.pop_front();
          n_checked++;
          if (want.clipped) n_clipped++;
          if (want.zero_radius) n_origin++;
          if (got !== want || m_axis_tdata[OUT_W-1:3*ACCEL_W+2] !== '0) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h zr=%b cl=%b", $time,
                     want.acc_x, want.acc_y, want.acc_z, want.zero_radius, want.clipped);
            $display("%0t:          actual   x=%h y=%h z=%h zr=%b cl=%b pad=%h", $time,
                     got.acc_x, got.acc_y, got.acc_z, got.zero_radius, got.clipped,
                     m_axis_tdata[OUT_W-1:3*ACCEL_W+2]);
            n_errors++;
          end
        end
      end
    end
  end

  // Directed corner cases: origin, coordinate extremes, a zero parameter and
  // saturation in both directions.
  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    rx_mode = 0;
    set_config(32'd0, 32'd0);
    send_pos(32'd0, 32'd0, 32'd0);
    send_pos(32'd100, -32'd7, 32'd3);
    send_pos(mx, mn, 32'd1);
    set_config(32'hffff_ffff, 32'd0);
    send_pos(32'd0, 32'd0, 32'd0);
    send_pos(32'd1, 32'd0, 32'd0);
    send_pos(-32'd1, 32'd0, 32'd0);
    send_pos(mn, mn, mn);
    send_pos(mx, mx, mx);
    send_pos(mn, 32'd0, 32'd0);
    send_pos(32'd0, mx, 32'd0);
    set_config(32'd1000, 32'd63);
    send_pos(32'd2, -32'd3, 32'd1);
    send_pos(mx, mn, mx);
    send_pos(32'd0, 32'd0, -32'd1);
    send_pos(32'd0, 32'd0, 32'd0);
    set_config(32'd12345, 32'd20);
    send_pos(32'd1000, 32'd2000, -32'd3000);
    send_pos(-32'd50000, 32'd1, 32'd0);
    send_pos(32'd7, 32'd7, 32'd7);
  endtask

  // Random positions under several register settings and receiver patterns.
  task automatic test_random(int n_phases, int per_phase);
    logic [31:0] gm, sh;
    for (int p = 0; p < n_phases; p++) begin
      case ($urandom_range(0, 5))
        0: gm = 32'hffff_ffff;
        1: gm = $urandom_range(0, 1);
        2: gm = $urandom_range(0, 255);
        default: gm = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0: sh = 32'd63;
        1: sh = 32'd0;
        default: sh = $urandom();  // upper bits must be ignored
      endcase
      set_config(gm, sh);
      rx_mode = p % 3;
      for (int i = 0; i < per_phase; i++)
        send_pos(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // The receiver blocks for a long stretch while requests keep coming,
  // so the pipeline fills and stalls its input.
  task automatic test_backpressure();
    set_config($urandom(), $urandom_range(0, 40));
    rx_mode = 1;
    hold_req = 1;
    for (int i = 0; i < 150; i++)
      send_pos(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gm_reg = '0;
    shift_reg = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(20, 90);
    wait_idle();
    $display("Covered %0d positions, %0d results checked (%0d saturated, %0d at origin).",
             n_sent, n_checked, n_clipped, n_origin);
    $display("Register settings varied across directed, back-pressure and random phases.");
    if (n_errors == 0 && accel_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
